/* hw/rtl/fisr_pkg.sv */
// ----------------------------------------------------------------------------
// fisr_pkg: shared types and float helpers for the reciprocal square root core
// binary32 unpack, multiply and add front ends, leading-one search and
// round-to-nearest-even packing, all with subnormal support
// ----------------------------------------------------------------------------
`default_nettype none

package fisr_pkg;

	localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
	localparam logic [31:0] FP_HALF     = 32'h3F000000;
	localparam logic [31:0] FP_ONE_HALF = 32'h3FC00000;
	localparam logic [31:0] CANON_NAN   = 32'h7FC00000;
	localparam int          SIG_W       = 74;
	localparam int          SIDE_W      = 64;
	localparam int          NEWTON_STEPS_DEF = 1;

	// unrounded result: value is sig * 2^(be - 127 - 72 + 23 - 23) scaled so
	// that a leading one at bit 72 means biased exponent be
	typedef struct packed {
		logic                nan;
		logic                inf;
		logic                zero;
		logic                sign;
		logic [SIG_W-1:0]    sig;
		logic signed [10:0]  be;
	} norm_t;

	function automatic logic is_nan(logic [31:0] f);
		return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(logic [31:0] f);
		return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
	endfunction

	function automatic logic [7:0] eff_exp(logic [31:0] f);
		return (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
	endfunction

	function automatic logic [23:0] mant(logic [31:0] f);
		return {f[30:23] != 8'd0, f[22:0]};
	endfunction

	function automatic norm_t fmul_front(logic [31:0] a, logic [31:0] b);
		norm_t       r;
		logic [47:0] p;
		logic        a_zero;
		logic        b_zero;
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		p      = mant(a) * mant(b);
		r.sig  = {p, 26'd0};
		r.be   = signed'({3'd0, eff_exp(a)}) + signed'({3'd0, eff_exp(b)}) - 11'sd127;
		r.sign = a[31] ^ b[31];
		r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && b_zero) || (a_zero && is_inf(b));
		r.inf  = is_inf(a) || is_inf(b);
		r.zero = a_zero || b_zero;
		return r;
	endfunction

	function automatic norm_t fadd_front(logic [31:0] a, logic [31:0] b);
		norm_t       r;
		logic        a_big;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [7:0]  eh;
		logic [7:0]  el;
		logic [7:0]  d;
		logic [49:0] xv;
		logic [49:0] yv;
		logic [49:0] lo_ext;
		logic [49:0] lost_mask;
		logic [50:0] s;
		a_big  = (a[30:0] >= b[30:0]);
		hi     = a_big ? a : b;
		lo     = a_big ? b : a;
		eh     = eff_exp(hi);
		el     = eff_exp(lo);
		d      = eh - el;
		xv     = {mant(hi), 26'd0};
		lo_ext = {mant(lo), 26'd0};
		if (d > 8'd50) begin
			yv = {49'd0, lo_ext != 50'd0};
		end else begin
			lost_mask = ~({50{1'b1}} << d);
			yv        = lo_ext >> d;
			yv[0]     = yv[0] | (|(lo_ext & lost_mask));
		end
		if (hi[31] == lo[31]) begin
			s = {1'b0, xv} + {1'b0, yv};
		end else begin
			s = {1'b0, xv} - {1'b0, yv};
		end
		r.sig  = {s, 23'd0};
		r.be   = signed'({3'd0, eh});
		r.zero = (s == 51'd0);
		r.sign = r.zero ? (a[31] & b[31]) : hi[31];
		r.inf  = is_inf(a) || is_inf(b);
		if (r.inf) begin
			r.sign = is_inf(a) ? a[31] : b[31];
		end
		r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]));
		return r;
	endfunction

	function automatic logic [6:0] lead_one(logic [SIG_W-1:0] sig);
		logic [6:0] pos;
		pos = 7'd0;
		for (int i = 0; i < SIG_W; i++) begin
			if (sig[i]) begin
				pos = 7'(i);
			end
		end
		return pos;
	endfunction

	function automatic logic [31:0] round_pack(norm_t n, logic [6:0] lead);
		logic signed [10:0] re;
		logic [10:0]        dn;
		logic [10:0]        shw;
		logic [6:0]         shs;
		logic [74:0]        nx;
		logic [74:0]        kept;
		logic [74:0]        gtmp;
		logic [74:0]        restm;
		logic               guard;
		logic               rest;
		logic               inc;
		logic [7:0]         expf;
		logic [30:0]        base;
		logic [30:0]        sum;
		logic [31:0]        res;
		re   = n.be + signed'({4'd0, lead}) - 11'sd72;
		dn   = (re < 11'sd1) ? 11'(11'sd1 - re) : 11'd0;
		shw  = {4'd0, lead} - 11'd23 + dn;
		shs  = (shw > 11'd75) ? 7'd75 : shw[6:0];
		nx   = {1'b0, n.sig};
		kept = nx >> shs;
		if (shs == 7'd0) begin
			guard = 1'b0;
			rest  = 1'b0;
		end else begin
			gtmp  = nx >> (shs - 7'd1);
			guard = gtmp[0];
			restm = ~({75{1'b1}} << (shs - 7'd1));
			rest  = |(nx & restm);
		end
		inc  = guard & (rest | kept[0]);
		expf = (re >= 11'sd1) ? re[7:0] : 8'd0;
		base = {expf, kept[22:0]};
		sum  = base + {30'd0, inc};
		if (n.nan) begin
			res = CANON_NAN;
		end else if (n.inf || (!n.zero && (re >= 11'sd255))) begin
			res = {n.sign, 8'hFF, 23'd0};
		end else if (n.zero) begin
			res = {n.sign, 31'd0};
		end else begin
			res = {n.sign, sum};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/fisr_op.sv */
// ----------------------------------------------------------------------------
// fisr_op: three-stage binary32 multiply or add
// stage 1 multiply or align/add, stage 2 leading-one search, stage 3 round
// ----------------------------------------------------------------------------
`default_nettype none

module fisr_op #(
	parameter bit IS_ADD = 1'b0
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [31:0]                 a,
	input  wire logic [31:0]                 b,
	input  wire logic [fisr_pkg::SIDE_W-1:0] side_in,
	output logic                             out_valid,
	output logic [31:0]                      result,
	output logic [fisr_pkg::SIDE_W-1:0]      side_out
);

	fisr_pkg::norm_t               front;
	fisr_pkg::norm_t               norm_s1;
	fisr_pkg::norm_t               norm_s2;
	logic [6:0]                    lead_s2;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          valid_s3;
	logic [fisr_pkg::SIDE_W-1:0]   side_s1;
	logic [fisr_pkg::SIDE_W-1:0]   side_s2;
	logic [fisr_pkg::SIDE_W-1:0]   side_s3;
	logic [31:0]                   res_s3;

	assign front = IS_ADD ? fisr_pkg::fadd_front(a, b) : fisr_pkg::fmul_front(a, b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		norm_s1 <= front;
		side_s1 <= side_in;
		norm_s2 <= norm_s1;
		lead_s2 <= fisr_pkg::lead_one(norm_s1.sig);
		side_s2 <= side_s1;
		res_s3  <= fisr_pkg::round_pack(norm_s2, lead_s2);
		side_s3 <= side_s2;
	end

	assign out_valid = valid_s3;
	assign result    = res_s3;
	assign side_out  = side_s3;

endmodule

`default_nettype wire

/* hw/rtl/fast_inverse_square_root_core.sv */
// ----------------------------------------------------------------------------
// fast_inverse_square_root_core: pipelined 0x5f3759df reciprocal square root
// magic-constant first guess followed by Newton steps in binary32 arithmetic
// ----------------------------------------------------------------------------
//
//  channel | signals                    | direction | handshake
//  --------+----------------------------+-----------+----------------------------
//  item in | start, busy, value_bits    | in        | taken when start && !busy
//  result  | done, rsqrt_bits           | out       | one-cycle strobe on done
//
//  one item enters per cycle; busy is never raised
//  the path is the half multiply of three stages, then per Newton step four
//  float ops of three stages each (multiply or add, leading-one search,
//  round), then the output register, which alone remains with no Newton steps
//  reset clears every valid bit; payload registers are not reset
//  the receiver cannot stall, so the pipeline never holds
//
`default_nettype none

module fast_inverse_square_root_core #(
	parameter int NEWTON_STEPS = fisr_pkg::NEWTON_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] value_bits,
	output logic             done,
	output logic [31:0]      rsqrt_bits
);

	localparam int LATENCY = (NEWTON_STEPS == 0) ? 1 : 4 + 12 * NEWTON_STEPS;

	logic        accept;
	logic [31:0] shifted;
	logic [31:0] guess;
	logic        fin_valid;
	logic [31:0] fin_bits;
	logic        done_q;
	logic [31:0] rsqrt_q;

	// no back pressure anywhere in the pipe
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// arithmetic shift right by one, then subtract from the magic constant
	assign shifted = {value_bits[31], value_bits[31:1]};
	assign guess   = fisr_pkg::MAGIC_GUESS - shifted;

	generate
		if (NEWTON_STEPS == 0) begin : g_guess_only
			assign fin_valid = accept;
			assign fin_bits  = guess;
		end else begin : g_newton
			logic                        v_w    [0:NEWTON_STEPS];
			logic [31:0]                 y_w    [0:NEWTON_STEPS];
			logic [31:0]                 half_w [0:NEWTON_STEPS];
			logic [31:0]                 half0;
			logic [fisr_pkg::SIDE_W-1:0] side0;

			// half = x * 0.5, the guess rides along
			fisr_op #(.IS_ADD(1'b0)) u_half (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (accept),
				.a        (value_bits),
				.b        (fisr_pkg::FP_HALF),
				.side_in  ({32'd0, guess}),
				.out_valid(v_w[0]),
				.result   (half0),
				.side_out (side0)
			);
			assign half_w[0] = half0;
			assign y_w[0]    = side0[31:0];

			for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
				logic        v1, v2, v3, v4;
				logic [31:0] t1, t2, t3, y_n;
				logic [fisr_pkg::SIDE_W-1:0] sd1, sd2, sd3, sd4;

				// t1 = half * y
				fisr_op #(.IS_ADD(1'b0)) u_m1 (
					.clk(clk), .arst_n(arst_n), .in_valid(v_w[k]),
					.a(half_w[k]), .b(y_w[k]), .side_in({half_w[k], y_w[k]}),
					.out_valid(v1), .result(t1), .side_out(sd1)
				);
				// t2 = t1 * y
				fisr_op #(.IS_ADD(1'b0)) u_m2 (
					.clk(clk), .arst_n(arst_n), .in_valid(v1),
					.a(t1), .b(sd1[31:0]), .side_in(sd1),
					.out_valid(v2), .result(t2), .side_out(sd2)
				);
				// t3 = 1.5 - t2, done as 1.5 + (-t2)
				fisr_op #(.IS_ADD(1'b1)) u_sub (
					.clk(clk), .arst_n(arst_n), .in_valid(v2),
					.a(fisr_pkg::FP_ONE_HALF), .b({~t2[31], t2[30:0]}), .side_in(sd2),
					.out_valid(v3), .result(t3), .side_out(sd3)
				);
				// y = y * t3
				fisr_op #(.IS_ADD(1'b0)) u_m3 (
					.clk(clk), .arst_n(arst_n), .in_valid(v3),
					.a(sd3[31:0]), .b(t3), .side_in(sd3),
					.out_valid(v4), .result(y_n), .side_out(sd4)
				);
				assign v_w[k+1]    = v4;
				assign y_w[k+1]    = y_n;
				assign half_w[k+1] = sd4[63:32];
			end

			// any nan coming out of the steps is already the canonical quiet nan
			assign fin_valid = v_w[NEWTON_STEPS];
			assign fin_bits  = y_w[NEWTON_STEPS];
		end
	endgenerate

	// output register: done strobes for exactly one cycle per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		rsqrt_q <= fin_bits;
	end

	assign done       = done_q;
	assign rsqrt_bits = rsqrt_q;

`ifndef SYNTHESIS
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result strobe missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(arst_n, LATENCY) |-> $past(start, LATENCY))
		else $error("result strobe without an item");

	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		done && (NEWTON_STEPS != 0) && (rsqrt_bits[30:23] == 8'hFF)
			&& (rsqrt_bits[22:0] != 23'd0) |-> rsqrt_bits == fisr_pkg::CANON_NAN)
		else $error("nan result not canonical");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for fast_inverse_square_root_core
// drives binary32 patterns into the core with random gaps and compares every
// done strobe against a typed-in value or a bit-exact software predictor of the magic-constant
// guess and one Newton step, rounding to nearest even with subnormals
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM  = 1900;
	localparam int WDOG_MAX  = 5000;
	localparam int DRAIN_CYC = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value_bits;
	logic        done;
	logic [31:0] rsqrt_bits;

	// expected results, oldest first
	logic [31:0] rsqrt_queue[$];
	int          mismatches;
	int          idle_cycles;
	bit          timed_out;

	fast_inverse_square_root_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value_bits (value_bits),
		.done       (done),
		.rsqrt_bits (rsqrt_bits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// binary32 predictor
	// ------------------------------------------------------------------------

	function automatic logic f32_nan(logic [31:0] f);
		return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
	endfunction

	function automatic logic f32_inf(logic [31:0] f);
		return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
	endfunction

	// significand with hidden bit, and exponent with subnormals read as 1
	function automatic logic [23:0] f32_sig(logic [31:0] f);
		return {f[30:23] != 8'd0, f[22:0]};
	endfunction

	function automatic int f32_exp(logic [31:0] f);
		return (f[30:23] == 8'd0) ? 1 : int'(f[30:23]);
	endfunction

	// rounds sign * mag * 2^e to binary32, nearest even
	function automatic logic [31:0] f32_round(logic sgn, logic [63:0] mag, int e);
		int          lead;
		int          sh;
		longint      fld;
		logic [63:0] kept;
		logic [63:0] restm;
		logic        guard;
		logic        rest;
		longint      packed_val;
		if (mag == 64'd0)
			return {sgn, 31'd0};
		lead = 0;
		for (int i = 0; i < 64; i++)
			if (mag[i])
				lead = i;
		// keep 24 bits, but never below the subnormal lsb weight 2^-149
		sh = lead - 23;
		if (sh < -149 - e)
			sh = -149 - e;
		// hidden bit in kept adds one to the exponent field
		fld = (sh == lead - 23) ? longint'(lead + e + 126) : 0;
		if (sh <= 0) begin
			kept  = mag << (-sh);
			guard = 1'b0;
			rest  = 1'b0;
		end else begin
			kept  = (sh >= 64) ? 64'd0 : mag >> sh;
			guard = (sh - 1 >= 64) ? 1'b0 : mag[sh-1];
			restm = (sh - 1 >= 64) ? '1 : (64'd1 << (sh - 1)) - 64'd1;
			rest  = |(mag & restm);
		end
		packed_val = (fld << 23) + longint'(kept) + longint'(guard & (rest | kept[0]));
		if (packed_val >= 64'h7F800000)
			return {sgn, 8'hFF, 23'd0};
		return {sgn, packed_val[30:0]};
	endfunction

	function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
		logic sgn;
		logic a_zero;
		logic b_zero;
		sgn    = a[31] ^ b[31];
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		if (f32_nan(a) || f32_nan(b) || (f32_inf(a) && b_zero) || (a_zero && f32_inf(b)))
			return fisr_pkg::CANON_NAN;
		if (f32_inf(a) || f32_inf(b))
			return {sgn, 8'hFF, 23'd0};
		if (a_zero || b_zero)
			return {sgn, 31'd0};
		return f32_round(sgn, 64'(f32_sig(a)) * 64'(f32_sig(b)),
			f32_exp(a) + f32_exp(b) - 300);
	endfunction

	function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] hi;
		logic [31:0] lo;
		int          d;
		logic [63:0] xv;
		logic [63:0] lo_ext;
		logic [63:0] yv;
		logic [63:0] sum;
		if (f32_nan(a) || f32_nan(b) || (f32_inf(a) && f32_inf(b) && a[31] != b[31]))
			return fisr_pkg::CANON_NAN;
		if (f32_inf(a))
			return a;
		if (f32_inf(b))
			return b;
		hi = (a[30:0] >= b[30:0]) ? a : b;
		lo = (a[30:0] >= b[30:0]) ? b : a;
		d  = f32_exp(hi) - f32_exp(lo);
		// 39 spare low bits plus a sticky lsb keep rounding exact
		xv     = 64'(f32_sig(hi)) << 39;
		lo_ext = 64'(f32_sig(lo)) << 39;
		if (d >= 64) begin
			yv = {63'd0, lo_ext != 64'd0};
		end else begin
			yv    = lo_ext >> d;
			yv[0] = yv[0] | (|(lo_ext & ((64'd1 << d) - 64'd1)));
		end
		sum = (hi[31] == lo[31]) ? xv + yv : xv - yv;
		// exact cancellation gives +0 unless both operands are negative
		if (sum == 64'd0)
			return {a[31] & b[31], 31'd0};
		return f32_round(hi[31], sum, f32_exp(hi) - 150 - 39);
	endfunction

	// magic guess then one Newton step, as the core is built by default
	function automatic logic [31:0] rsqrt_predict(logic [31:0] x);
		logic [31:0] y;
		logic [31:0] half;
		logic [31:0] t;
		y    = fisr_pkg::MAGIC_GUESS - {x[31], x[31:1]};
		half = f32_mul(x, fisr_pkg::FP_HALF);
		for (int k = 0; k < fisr_pkg::NEWTON_STEPS_DEF; k++) begin
			t = f32_mul(half, y);
			t = f32_mul(t, y);
			t = f32_add(fisr_pkg::FP_ONE_HALF, {~t[31], t[30:0]});
			y = f32_mul(y, t);
		end
		if (fisr_pkg::NEWTON_STEPS_DEF > 0 && f32_nan(y))
			y = fisr_pkg::CANON_NAN;
		return y;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	typedef struct {
		logic [31:0] value;
		bit          typed;    // expectation typed in below
		logic [31:0] rsqrt;
	} vec_t;

	// directed rows: extremes, signed zeros, subnormals, infinities, nans,
	// negative inputs and magic subtraction wraparound
	localparam int N_DIR = 20;
	vec_t dir_tab[N_DIR] = '{
		'{32'h00000000, 0, 32'h0},            // +0
		'{32'h80000000, 0, 32'h0},            // -0, guess wraps
		'{32'h00000001, 0, 32'h0},            // smallest subnormal
		'{32'h007FFFFF, 0, 32'h0},            // largest subnormal
		'{32'h00800000, 0, 32'h0},            // smallest normal
		'{32'h7F7FFFFF, 0, 32'h0},            // largest normal
		'{32'h7F800000, 0, 32'h0},            // +inf
		'{32'hFF800000, 0, 32'h0},            // -inf
		'{32'h7FC00000, 1, 32'h7FC00000},     // quiet nan stays canonical
		'{32'h7F800001, 1, 32'h7FC00000},     // signaling nan
		'{32'hFFFFFFFF, 1, 32'h7FC00000},     // negative nan, all ones
		'{32'h3F800000, 0, 32'h0},            // 1.0
		'{32'h40800000, 0, 32'h0},            // 4.0
		'{32'h3E800000, 0, 32'h0},            // 0.25
		'{32'hBF800000, 0, 32'h0},            // -1.0
		'{32'h80000001, 0, 32'h0},            // negative subnormal
		'{32'hFF7FFFFF, 0, 32'h0},            // most negative normal
		'{32'h5F3759DF, 0, 32'h0},            // the magic pattern itself
		'{32'h3F7FFFFF, 0, 32'h0},            // just below 1.0
		'{32'h55555555, 0, 32'h0}             // alternating bits
	};

	// expectation pushed alongside each item so the monitor can pick it up
	logic [31:0] drive_expect;

	function automatic logic [31:0] random_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: ;                                          // any pattern
			3, 4, 5, 6: v[31:23] = {1'b0, 8'($urandom_range(64, 190))};
			7: v[30:23] = 8'd0;                                 // subnormal
			8: v[30:23] = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'd0;
			default: v[31:23] = {1'b1, 8'($urandom_range(1, 254))};
		endcase
		return v;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// holds the item until a clock edge takes it, busy checked mid-cycle
	task automatic send_item(logic [31:0] v, logic [31:0] exp_rsqrt);
		bit taken;
		start        <= 1'b1;
		value_bits   <= v;
		drive_expect <= exp_rsqrt;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		logic [31:0] v;
		start        = 1'b0;
		value_bits   = '0;
		drive_expect = '0;
		arst_n       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			v = dir_tab[i].value;
			send_item(v, dir_tab[i].typed ? dir_tab[i].rsqrt : rsqrt_predict(v));
			idle_gap(gap_len());
		end

		// random part, with bursts that run back to back
		for (int i = 0; i < N_RANDOM; i++) begin
			v = random_value();
			send_item(v, rsqrt_predict(v));
			if ((i / 100) % 3 != 1)
				idle_gap(gap_len());
		end
		start <= 1'b0;

		wait (rsqrt_queue.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && rsqrt_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// monitor: records taken items, checks each done strobe in order
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (start && !busy)
				rsqrt_queue.push_back(drive_expect);
			if (done) begin
				if (rsqrt_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with nothing expected: rsqrt_bits=%h", rsqrt_bits);
				end else begin
					want = rsqrt_queue.pop_front();
					if (rsqrt_bits !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("rsqrt_bits mismatch: expected %h got %h", want,
								rsqrt_bits);
					end
				end
			end
		end
	end

	// watchdog: cycles in which no item and no result moved
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX && !timed_out) begin
				timed_out <= 1'b1;
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		mismatches  = 0;
		idle_cycles = 0;
		timed_out   = 1'b0;
	end

endmodule

`default_nettype wire
